// ----- rtl/cpfb_pkg.sv -----
// ----------------------------------------------------------------------------
// CoAP PUT frame builder package
// Shared request, response and queue entry types and the fixed message bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package cpfb_pkg;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   localparam logic [1:0] SEG_URI     = 2'd0;
   localparam logic [1:0] SEG_QUERY   = 2'd1;
   localparam logic [1:0] SEG_QUERY2  = 2'd2;
   localparam logic [1:0] SEG_PAYLOAD = 2'd3;

   localparam logic [7:0] HDR_VER_TYPE   = 8'b0101_0000;
   localparam logic [7:0] HDR_CODE_PUT   = 8'b0000_0011;
   localparam logic [7:0] OPT_URI_PATH   = 8'hB0;
   localparam logic [7:0] OPT_URI_QUERY  = 8'h40;
   localparam logic [7:0] OPT_QUERY_NEXT = 8'h00;
   localparam logic [7:0] OPT_EXT_LEN    = 8'h0D;
   localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
   localparam logic [8:0] SHORT_LEN_MAX  = 9'd12;
   localparam logic [8:0] EXT_LEN_BIAS   = 9'd13;
   localparam logic [8:0] EXT_LEN_MAX    = 9'd268;

   typedef struct packed {
      logic       func;
      logic [1:0] segment;
      logic [8:0] segment_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic        hdr;
      logic [15:0] msg_id;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic        two;
      logic        last;
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/cpfb_front.sv -----
// ----------------------------------------------------------------------------
// CoAP PUT frame builder front end
// Accepts requests, tracks message and payload state and queues byte jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfb_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cpfb_pkg::req_type req_payload,
   input  wire logic             q_full,
   output logic                  push,
   output cpfb_pkg::job_type     push_job
);
   import cpfb_pkg::*;

   logic [15:0] msg_id_ff, msg_id_in;
   logic [8:0]  remaining_ff, remaining_in;
   logic        in_payload_ff, in_payload_in;
   logic        accept;
   logic        has_job;
   logic [8:0]  len;
   logic [8:0]  rem_dec;
   logic [7:0]  ext_len;
   logic        short_len;
   logic [7:0]  opt_base;
   job_type     job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign len       = req_payload.segment_length;
   assign short_len = (len <= SHORT_LEN_MAX);
   assign rem_dec   = (remaining_ff != 9'd0) ? remaining_ff - 9'd1 : remaining_ff;

   always_comb begin
      logic [8:0] diff;
      diff    = len - EXT_LEN_BIAS;
      ext_len = (len > EXT_LEN_MAX) ? 8'hFF : diff[7:0];
   end

   always_comb begin
      msg_id_in        = msg_id_ff;
      remaining_in     = remaining_ff;
      in_payload_in    = in_payload_ff;
      has_job          = 1'b1;
      opt_base         = OPT_URI_PATH;
      job.hdr          = 1'b0;
      job.msg_id       = msg_id_ff;
      job.first_byte   = req_payload.data_byte;
      job.second_byte  = ext_len;
      job.two          = 1'b0;
      job.last         = 1'b0;
      if (req_payload.func == FUNC_DATA) begin
         if (in_payload_ff) begin
            remaining_in = rem_dec;
            if (rem_dec == 9'd0) begin
               job.last      = 1'b1;
               in_payload_in = 1'b0;
            end
         end
      end else begin
         remaining_in  = 9'd0;
         in_payload_in = 1'b0;
         case (req_payload.segment)
            SEG_URI: begin
               msg_id_in  = msg_id_ff + 16'd1;
               job.hdr    = 1'b1;
               job.msg_id = msg_id_in;
               opt_base   = OPT_URI_PATH;
            end
            SEG_QUERY: begin
               opt_base = OPT_URI_QUERY;
            end
            SEG_QUERY2: begin
               opt_base = OPT_QUERY_NEXT;
               has_job  = (len != 9'd0);
            end
            default: begin
               opt_base = PAYLOAD_MARKER;
               if (len != 9'd0) begin
                  remaining_in  = len;
                  in_payload_in = 1'b1;
               end else begin
                  job.last = 1'b1;
               end
            end
         endcase
         if (req_payload.segment == SEG_PAYLOAD) begin
            job.first_byte = PAYLOAD_MARKER;
         end else if (short_len) begin
            job.first_byte = opt_base | len[7:0];
         end else begin
            job.first_byte = opt_base | OPT_EXT_LEN;
            job.two        = 1'b1;
         end
      end
   end

   assign push     = accept && has_job;
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_id_ff     <= '0;
         remaining_ff  <= '0;
         in_payload_ff <= 1'b0;
      end else if (accept) begin
         msg_id_ff     <= msg_id_in;
         remaining_ff  <= remaining_in;
         in_payload_ff <= in_payload_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cpfb_queue.sv -----
// ----------------------------------------------------------------------------
// CoAP PUT frame builder job queue
// A short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfb_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cpfb_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   head_valid,
   output cpfb_pkg::job_type      head_job,
   output logic                   q_full
);
   import cpfb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign q_full     = (count_ff == CW'(DEPTH));
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cpfb_back.sv -----
// ----------------------------------------------------------------------------
// CoAP PUT frame builder back end
// Expands queued jobs into message bytes and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire cpfb_pkg::job_type head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cpfb_pkg::rsp_type      rsp_payload
);
   import cpfb_pkg::*;

   localparam logic [2:0] IDX_VER    = 3'd0;
   localparam logic [2:0] IDX_CODE   = 3'd1;
   localparam logic [2:0] IDX_ID_HI  = 3'd2;
   localparam logic [2:0] IDX_ID_LO  = 3'd3;
   localparam logic [2:0] IDX_FIRST  = 3'd4;
   localparam logic [2:0] IDX_SECOND = 3'd5;

   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] idx;
   logic       out_free;
   logic       emit;
   logic       final_byte;
   logic [7:0] cur_byte;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = head_valid && out_free;
   assign idx        = head_job.hdr ? step_ff : step_ff + IDX_FIRST;
   assign final_byte = (idx == IDX_SECOND) || ((idx == IDX_FIRST) && !head_job.two);
   assign pop        = emit && final_byte;

   always_comb begin
      case (idx)
         IDX_VER:    cur_byte = HDR_VER_TYPE;
         IDX_CODE:   cur_byte = HDR_CODE_PUT;
         IDX_ID_HI:  cur_byte = head_job.msg_id[15:8];
         IDX_ID_LO:  cur_byte = head_job.msg_id[7:0];
         IDX_FIRST:  cur_byte = head_job.first_byte;
         default:    cur_byte = head_job.second_byte;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      if (emit) begin
         step_in          = final_byte ? 3'd0 : step_ff + 3'd1;
         rsp_in.out_byte  = cur_byte;
         rsp_in.last_byte = final_byte && head_job.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/coap_put_frame_builder_core.sv -----
// ----------------------------------------------------------------------------
// CoAP PUT frame builder core
// A request is accepted into the job queue, and its first byte is then expanded
// by the back end and registered in the output register.
// Data requests sustain one byte per cycle while the output is not stalled; a uri
// start yields five or six output bytes, an option one or two and a marker one.
// Reset clears the message ID, the payload state, the job queue and rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module coap_put_frame_builder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cpfb_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cpfb_pkg::rsp_type      rsp_payload
);
   import cpfb_pkg::*;

   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;
   logic    q_full;

   cpfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   cpfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .q_full     (q_full)
   );

   cpfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// CoAP PUT frame builder testbench
// Feeds uri, query, payload and data requests with random content into the core,
// predicts every message byte and its last flag, and checks each response
// against the oldest prediction while both sides first idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import cpfb_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int TARGET_ITEMS   = 430;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      req_type item;
      bit      hold;
   } backlog_entry_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   backlog_entry_type request_backlog[$];
   rsp_type           expected_bytes[$];
   rsp_type           want;

   logic [15:0] model_msg_id   = '0;
   logic [8:0]  model_pay_left = '0;
   logic        model_in_pay   = 1'b0;

   bit hold_next   = 1'b0;
   bit req_taken   = 1'b0;
   int errors      = 0;
   int sent_count  = 0;
   int total_items = 1;
   int idle_pct;
   int stall_pct;
   int quiet_cycles = 0;

   coap_put_frame_builder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic queue_byte(input logic [7:0] value, input logic last);
      rsp_type r;
      r.out_byte  = value;
      r.last_byte = last;
      expected_bytes.push_back(r);
   endtask

   task automatic queue_option(input logic [7:0] base, input logic [8:0] len);
      logic [8:0] ext;
      if (len <= SHORT_LEN_MAX) begin
         queue_byte(base | len[7:0], 1'b0);
      end else begin
         ext = len - EXT_LEN_BIAS;
         queue_byte(base | OPT_EXT_LEN, 1'b0);
         queue_byte((len > EXT_LEN_MAX) ? 8'hFF : ext[7:0], 1'b0);
      end
   endtask

   task automatic encode_request(input req_type q);
      logic last;
      if (q.func == FUNC_DATA) begin
         last = 1'b0;
         if (model_in_pay) begin
            if (model_pay_left != 9'd0) model_pay_left = model_pay_left - 9'd1;
            if (model_pay_left == 9'd0) begin
               last         = 1'b1;
               model_in_pay = 1'b0;
            end
         end
         queue_byte(q.data_byte, last);
      end else begin
         case (q.segment)
            SEG_URI: begin
               model_in_pay   = 1'b0;
               model_pay_left = '0;
               model_msg_id   = model_msg_id + 16'd1;
               queue_byte(HDR_VER_TYPE, 1'b0);
               queue_byte(HDR_CODE_PUT, 1'b0);
               queue_byte(model_msg_id[15:8], 1'b0);
               queue_byte(model_msg_id[7:0], 1'b0);
               queue_option(OPT_URI_PATH, q.segment_length);
            end
            SEG_QUERY: begin
               model_in_pay   = 1'b0;
               model_pay_left = '0;
               queue_option(OPT_URI_QUERY, q.segment_length);
            end
            SEG_QUERY2: begin
               model_in_pay   = 1'b0;
               model_pay_left = '0;
               if (q.segment_length != 9'd0) queue_option(OPT_QUERY_NEXT, q.segment_length);
            end
            default: begin
               if (q.segment_length == 9'd0) begin
                  model_in_pay   = 1'b0;
                  model_pay_left = '0;
                  queue_byte(PAYLOAD_MARKER, 1'b1);
               end else begin
                  model_in_pay   = 1'b1;
                  model_pay_left = q.segment_length;
                  queue_byte(PAYLOAD_MARKER, 1'b0);
               end
            end
         endcase
      end
   endtask

   task automatic add_item(input logic func, input logic [1:0] seg, input logic [8:0] len,
                           input logic [7:0] value);
      backlog_entry_type e;
      e.item.func           = func;
      e.item.segment        = seg;
      e.item.segment_length = len;
      e.item.data_byte      = value;
      e.hold                = hold_next;
      hold_next             = 1'b0;
      request_backlog.push_back(e);
   endtask

   task automatic add_start(input logic [1:0] seg, input logic [8:0] len);
      add_item(FUNC_START, seg, len, 8'($urandom_range(255, 0)));
   endtask

   task automatic add_data(input logic [7:0] value);
      add_item(FUNC_DATA, 2'($urandom_range(3, 0)), 9'($urandom_range(511, 0)), value);
   endtask

   task automatic add_text(input int count);
      repeat (count) add_data(8'($urandom_range(255, 0)));
   endtask

   function automatic logic [8:0] pick_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return 9'($urandom_range(12, 0));
      if (r < 88) return 9'($urandom_range(24, 13));
      return 9'($urandom_range(511, 0));
   endfunction

   task automatic add_segment(input logic [1:0] seg);
      logic [8:0] len;
      len = pick_length();
      add_start(seg, len);
      add_text((len > 9'd24) ? int'($urandom_range(6, 0)) : int'(len));
   endtask

   always @(negedge clock) begin
      if (sent_count < total_items / 3) begin
         idle_pct  = 21;
         stall_pct = 75;
      end else if (sent_count < 2 * total_items / 3) begin
         idle_pct  = 75;
         stall_pct = 21;
      end else begin
         idle_pct  = 0;
         stall_pct = 0;
      end
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
         if (!req_valid || req_taken) begin
            if (request_backlog.size() != 0
                && !(request_backlog[0].hold && expected_bytes.size() != 0)
                && $urandom_range(99, 0) >= idle_pct) begin
               req_payload <= request_backlog[0].item;
               req_valid   <= 1'b1;
               request_backlog.pop_front();
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("Unexpected byte %h last %b", rsp_payload.out_byte,
                           rsp_payload.last_byte);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_payload.out_byte !== want.out_byte
                   || rsp_payload.last_byte !== want.last_byte) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("Byte mismatch: expected %h last %b, got %h last %b",
                              want.out_byte, want.last_byte, rsp_payload.out_byte,
                              rsp_payload.last_byte);
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            encode_request(req_payload);
         end
         if (req_taken || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   initial begin
      add_start(SEG_URI, 9'd0);
      add_start(SEG_URI, 9'd12);
      add_start(SEG_URI, 9'd13);
      add_start(SEG_URI, 9'd511);
      add_start(SEG_QUERY, 9'd12);
      add_start(SEG_QUERY, 9'd13);
      add_start(SEG_QUERY, 9'd268);
      add_start(SEG_QUERY2, 9'd0);
      add_start(SEG_QUERY2, 9'd7);
      add_start(SEG_QUERY2, 9'd269);
      add_start(SEG_PAYLOAD, 9'd0);
      add_data(8'h00);
      add_start(SEG_PAYLOAD, 9'd1);
      add_data(8'hFF);
      add_start(SEG_PAYLOAD, 9'd2);
      add_data(8'hA5);
      add_data(8'h5A);
      add_data(8'h3C);
      add_start(SEG_PAYLOAD, 9'd256);
      add_start(SEG_URI, 9'd3);
      add_text(3);

      hold_next = 1'b1;
      while (request_backlog.size() < TARGET_ITEMS) begin
         if ($urandom_range(99, 0) < 85) begin
            add_segment(SEG_URI);
            if ($urandom_range(99, 0) < 70) add_segment(SEG_QUERY);
            if ($urandom_range(99, 0) < 50) add_segment(SEG_QUERY2);
            add_segment(SEG_PAYLOAD);
            if ($urandom_range(99, 0) < 10) add_text($urandom_range(3, 1));
         end else begin
            repeat ($urandom_range(4, 1))
               add_item(1'($urandom_range(1, 0)), 2'($urandom_range(3, 0)),
                        9'($urandom_range(511, 0)), 8'($urandom_range(255, 0)));
         end
         if ($urandom_range(99, 0) < 12) hold_next = 1'b1;
      end
      total_items = request_backlog.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
